/* hdl/eld2d_pkg.sv */
// Package for the 2D Euler integrator with linear drag.
// Holds register indexes, reset values, fixed-point constants and saturation helpers.
// No dependencies.
package eld2d_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TIME_STEP  = 2'd0,
		CFG_STATE_MASK = 2'd1,
		CFG_COMP_MASK  = 2'd2
	} cfg_index_t;

	// Register reset values
	localparam logic [15:0] TIME_STEP_RESET  = 16'd1092;
	localparam logic [31:0] STATE_MASK_RESET = 32'd7;
	localparam logic [31:0] COMP_MASK_RESET  = 32'd3;

	// Fixed-point constants: 1.0 in Q16.16, half an LSB for round-half-up
	localparam logic [25:0] ONE_Q16  = 26'h001_0000;
	localparam int unsigned HALF_Q16 = 32768;

	// Widths of intermediate values
	localparam int unsigned DISP_W   = 49;  // vel * time_step
	localparam int unsigned DELTA_W  = 33;  // rounded displacement
	localparam int unsigned DTERM_W  = 40;  // time_step * damping
	localparam int unsigned FACTOR_W = 26;  // signed damping factor
	localparam int unsigned VPROD_W  = 58;  // vel * factor
	localparam int unsigned VRND_W   = 42;  // rounded damped velocity

	typedef logic signed [31:0] q16_t;

	// Clamp a 34-bit signed sum to 32 bits
	function automatic q16_t sat_sum(input logic signed [33:0] v);
		q16_t r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Clamp a 42-bit signed value to 32 bits
	function automatic q16_t sat_vel(input logic signed [VRND_W-1:0] v);
		q16_t r;
		if (v > 42'sh000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -42'sh000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hdl/euler_integrator_linear_drag_2d.sv */
// Throughput one item per cycle when the output is not back-pressured.
// Stages: s1 filter and step products, s2 rounding and damping factor,
// s3 position add and velocity-times-factor, s4 rounding, saturation, output register.
// A full stage holds only while the next stage holds, so bubbles collapse under back-pressure.
// arst_n clears all valid bits and loads the register reset values.
// File: top level of the 2D Euler integrator with linear drag; depends on eld2d_pkg.
module euler_integrator_linear_drag_2d
	import eld2d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// state_bits, component_bits, pos_x, pos_y, angle, vel_x, vel_y, spin,
	// linear_damping, angular_damping (lowest bit first)
	input  logic [303:0] s_axis_tdata,
	input  logic         s_axis_tuser,   // slot_used
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_angle, new_vel_x, new_vel_y, new_spin (lowest bit first)
	output logic [191:0] m_axis_tdata,
	output logic         m_axis_tuser    // selected
);

	// Configuration registers
	logic [15:0] time_step_q;
	logic [31:0] state_mask_q;
	logic [31:0] comp_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TIME_STEP_RESET;
			state_mask_q <= STATE_MASK_RESET;
			comp_mask_q  <= COMP_MASK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TIME_STEP:  time_step_q  <= cfg_data[15:0];
				CFG_STATE_MASK: state_mask_q <= cfg_data;
				CFG_COMP_MASK:  comp_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input unpacking
	logic [31:0] in_state, in_comp;
	q16_t        in_pos [3];
	q16_t        in_vel [3];
	logic [23:0] in_lin_damp, in_ang_damp;

	assign in_state    = s_axis_tdata[31:0];
	assign in_comp     = s_axis_tdata[63:32];
	assign in_pos[0]   = s_axis_tdata[95:64];
	assign in_pos[1]   = s_axis_tdata[127:96];
	assign in_pos[2]   = s_axis_tdata[159:128];
	assign in_vel[0]   = s_axis_tdata[191:160];
	assign in_vel[1]   = s_axis_tdata[223:192];
	assign in_vel[2]   = s_axis_tdata[255:224];
	assign in_lin_damp = s_axis_tdata[279:256];
	assign in_ang_damp = s_axis_tdata[303:280];

	// Stage handshake: a stage loads when empty or when the next one loads
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: filter and products with the time step
	logic                      sel_c;
	logic signed [16:0]        ts_sgn;
	logic signed [DISP_W-1:0]  disp_c [3];
	logic [DTERM_W-1:0]        dlin_c, dang_c;

	assign sel_c = s_axis_tuser
		&& ((in_state & state_mask_q) == state_mask_q)
		&& ((in_comp & comp_mask_q) == comp_mask_q);
	assign ts_sgn = $signed({1'b0, time_step_q});
	assign dlin_c = DTERM_W'(time_step_q) * DTERM_W'(in_lin_damp);
	assign dang_c = DTERM_W'(time_step_q) * DTERM_W'(in_ang_damp);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			disp_c[i] = DISP_W'(in_vel[i]) * DISP_W'(ts_sgn);
		end
	end

	logic                      sel_s1;
	q16_t                      pos_s1 [3];
	q16_t                      vel_s1 [3];
	logic signed [DISP_W-1:0]  disp_s1 [3];
	logic [DTERM_W-1:0]        dlin_s1, dang_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			sel_s1  <= sel_c;
			pos_s1  <= in_pos;
			vel_s1  <= in_vel;
			disp_s1 <= disp_c;
			dlin_s1 <= dlin_c;
			dang_s1 <= dang_c;
		end
	end

	// Stage 2: round displacements and form damping factors
	logic signed [DISP_W-1:0]   disp_rnd [3];
	logic signed [DELTA_W-1:0]  delta_c [3];
	logic [DTERM_W-1:0]         lin_rnd, ang_rnd;
	logic signed [FACTOR_W-1:0] flin_c, fang_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			disp_rnd[i] = disp_s1[i] + DISP_W'(HALF_Q16);
			delta_c[i]  = disp_rnd[i][DISP_W-1:16];
		end
	end

	assign lin_rnd = dlin_s1 + DTERM_W'(HALF_Q16);
	assign ang_rnd = dang_s1 + DTERM_W'(HALF_Q16);
	assign flin_c  = $signed(ONE_Q16 - {2'b00, lin_rnd[39:16]});
	assign fang_c  = $signed(ONE_Q16 - {2'b00, ang_rnd[39:16]});

	logic                       sel_s2;
	q16_t                       pos_s2 [3];
	q16_t                       vel_s2 [3];
	logic signed [DELTA_W-1:0]  delta_s2 [3];
	logic signed [FACTOR_W-1:0] flin_s2, fang_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			sel_s2   <= sel_s1;
			pos_s2   <= pos_s1;
			vel_s2   <= vel_s1;
			delta_s2 <= delta_c;
			flin_s2  <= flin_c;
			fang_s2  <= fang_c;
		end
	end

	// Stage 3: saturating position update, velocity times damping factor
	logic signed [33:0]        psum_c [3];
	q16_t                      npos_c [3];
	logic signed [VPROD_W-1:0] vprod_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum_c[i] = {{2{pos_s2[i][31]}}, pos_s2[i]} + {delta_s2[i][DELTA_W-1], delta_s2[i]};
			npos_c[i] = sat_sum(psum_c[i]);
		end
	end

	assign vprod_c[0] = VPROD_W'(vel_s2[0]) * VPROD_W'(flin_s2);
	assign vprod_c[1] = VPROD_W'(vel_s2[1]) * VPROD_W'(flin_s2);
	assign vprod_c[2] = VPROD_W'(vel_s2[2]) * VPROD_W'(fang_s2);

	logic                      sel_s3;
	q16_t                      pos_s3 [3];
	q16_t                      vel_s3 [3];
	q16_t                      npos_s3 [3];
	logic signed [VPROD_W-1:0] vprod_s3 [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			sel_s3   <= sel_s2;
			pos_s3   <= pos_s2;
			vel_s3   <= vel_s2;
			npos_s3  <= npos_c;
			vprod_s3 <= vprod_c;
		end
	end

	// Stage 4: round and saturate velocities, pick updated or original values
	logic signed [VPROD_W-1:0] vrnd_c [3];
	q16_t                      opos_c [3];
	q16_t                      ovel_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vrnd_c[i] = vprod_s3[i] + VPROD_W'(HALF_Q16);
			opos_c[i] = sel_s3 ? npos_s3[i] : pos_s3[i];
			ovel_c[i] = sel_s3 ? sat_vel(vrnd_c[i][VPROD_W-1:16]) : vel_s3[i];
		end
	end

	logic         sel_s4;
	logic [191:0] data_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sel_s4  <= sel_s3;
			data_s4 <= {ovel_c[2], ovel_c[1], ovel_c[0], opos_c[2], opos_c[1], opos_c[0]};
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = data_s4;
	assign m_axis_tuser  = sel_s4;

endmodule
